[hw/rtl/nnis_pkg.sv]
`timescale 1ns / 1ps
// Shared constants for the nearest-neighbour scaler: field widths, codes
// and parameter defaults. No dependencies.
package nnis_pkg;

   localparam int CFG_W        = 11;   // width of each dimension register
   localparam int CSR_IDX_W    = 2;
   localparam int ADDR_W       = 20;   // frame store address
   localparam int STORE_DEPTH  = 1 << ADDR_W;
   localparam int PIX_IN_W     = 32;
   localparam int PIX_W        = 24;   // stored blue/green/red
   localparam int POS_W        = 10;   // out_column / out_row
   localparam int REQ_DATA_W   = 56;   // 20 + 32 packed, padded to bytes
   localparam int RSP_DATA_W   = 56;   // 32 + 10 + 10 packed, padded

   localparam int MAX_WIDTH_DEF  = 1024;
   localparam int MAX_HEIGHT_DEF = 1024;

   localparam logic [7:0] ALPHA_OPAQUE = 8'hFF;

   localparam logic FUNC_LOAD = 1'b0;
   localparam logic FUNC_EMIT = 1'b1;

   localparam logic [CSR_IDX_W-1:0] REG_SRC_WIDTH  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_SRC_HEIGHT = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_DST_WIDTH  = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_DST_HEIGHT = 2'd3;

endpackage

[hw/rtl/nearest_neighbor_image_scaler_top.sv]
`timescale 1ns / 1ps
// A load word is written to the frame store in its accept cycle (one word per
// clock while idle; no word is taken while an emit is in flight). An emit word
// steps through MUL, DIV, ADDR, READ and LOAD; DIV runs the bit-per-cycle
// quotient loops until the longer quotient is complete, and LOAD holds until
// the result register is free. An emit with any zero dimension is accepted
// in IDLE and gives no result. Reset (synchronous, high) clears control,
// counters and the dimension registers; the frame store is not cleared.
module nearest_neighbor_image_scaler_top #(
   parameter int MAX_WIDTH  = nnis_pkg::MAX_WIDTH_DEF,
   parameter int MAX_HEIGHT = nnis_pkg::MAX_HEIGHT_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // input words
   input  logic                              req_tvalid,
   output logic                              req_tready,
   // [19:0] load_address, [51:20] load_pixel, [55:52] zero
   input  logic [nnis_pkg::REQ_DATA_W-1:0]   req_tdata,
   // [0] func
   input  logic                              req_tuser,
   // result words
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   // [31:0] out_pixel, [41:32] out_column, [51:42] out_row, [55:52] zero
   output logic [nnis_pkg::RSP_DATA_W-1:0]   rsp_tdata,
   // line_end
   output logic                              rsp_tlast,
   // [0] frame_end
   output logic                              rsp_tuser,
   // configuration writes
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [nnis_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [nnis_pkg::CFG_W-1:0]        csr_data
);
   import nnis_pkg::*;

   // column/row counter widths, clamped dimension widths
   localparam int XW   = $clog2(MAX_WIDTH);
   localparam int YW   = $clog2(MAX_HEIGHT);
   localparam int CW   = $clog2(MAX_WIDTH + 1);
   localparam int HW   = $clog2(MAX_HEIGHT + 1);
   localparam int WE_W = (CW > CFG_W) ? CW : CFG_W;
   localparam int HE_W = (HW > CFG_W) ? HW : CFG_W;
   localparam int PXW  = XW + CW;
   localparam int PYW  = YW + HW;
   localparam int KMAX = (XW > YW) ? XW : YW;
   localparam int CNT_W = $clog2(KMAX + 1);
   localparam int SUM_A = ((YW + CW) > XW) ? (YW + CW + 1) : (XW + 1);
   localparam int SUM_W = (SUM_A > ADDR_W) ? SUM_A : ADDR_W;

   localparam logic [2:0] ST_IDLE = 3'd0;
   localparam logic [2:0] ST_MUL  = 3'd1;
   localparam logic [2:0] ST_DIV  = 3'd2;
   localparam logic [2:0] ST_ADDR = 3'd3;
   localparam logic [2:0] ST_READ = 3'd4;
   localparam logic [2:0] ST_LOAD = 3'd5;

   logic [2:0]        state_ff, state_in;

   logic [CFG_W-1:0]  src_w_ff, src_h_ff, dst_w_ff, dst_h_ff;
   logic [XW-1:0]     col_ff;
   logic [YW-1:0]     row_ff;

   // item registers
   logic [XW-1:0]     x_ff;
   logic [YW-1:0]     y_ff;
   logic              le_ff, fe_ff;

   // quotient loops: remainder plus dividend low bits that turn into quotient
   logic [CW-1:0]     xrem_ff;
   logic [XW-1:0]     xlow_ff;
   logic [HW-1:0]     yrem_ff;
   logic [YW-1:0]     ylow_ff;
   logic [CNT_W-1:0]  cnt_ff;

   logic [ADDR_W-1:0] addr_ff;
   logic [PIX_W-1:0]  rd_ff;

   logic              rsp_valid_ff;
   logic [PIX_W-1:0]  rsp_pix_ff;
   logic [POS_W-1:0]  rsp_col_ff, rsp_row_ff;
   logic              rsp_le_ff, rsp_fe_ff;

   // frame store: written by load words, read once per emit that gives a result
   logic [PIX_W-1:0]  store_mem [STORE_DEPTH];

   // clamped dimensions
   logic [CW-1:0]     sw_c, tw_c;
   logic [HW-1:0]     sh_c, th_c;

   always_comb begin
      sw_c = (WE_W'(src_w_ff) > WE_W'(MAX_WIDTH))  ? CW'(MAX_WIDTH)  : CW'(src_w_ff);
      tw_c = (WE_W'(dst_w_ff) > WE_W'(MAX_WIDTH))  ? CW'(MAX_WIDTH)  : CW'(dst_w_ff);
      sh_c = (HE_W'(src_h_ff) > HE_W'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(src_h_ff);
      th_c = (HE_W'(dst_h_ff) > HE_W'(MAX_HEIGHT)) ? HW'(MAX_HEIGHT) : HW'(dst_h_ff);
   end

   logic req_fire, is_emit, dims_ok, emit_go, rsp_free;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_fire   = req_tvalid && req_tready;
   assign is_emit    = (req_tuser == FUNC_EMIT);
   assign dims_ok    = (sw_c != '0) && (sh_c != '0) && (tw_c != '0) && (th_c != '0);
   assign emit_go    = req_fire && is_emit && dims_ok;
   assign rsp_free   = !rsp_valid_ff || rsp_tready;

   // counters restart when beyond a lowered raster
   logic [XW-1:0] x_cur;
   logic [YW-1:0] y_cur;
   logic          le_cur, fe_cur;

   always_comb begin
      x_cur  = (CW'(col_ff) >= tw_c) ? '0 : col_ff;
      y_cur  = (HW'(row_ff) >= th_c) ? '0 : row_ff;
      le_cur = (CW'(x_cur) == (tw_c - CW'(1)));
      fe_cur = le_cur && (HW'(y_cur) == (th_c - HW'(1)));
   end

   // x*sw and y*sh feed the quotient loops
   logic [PXW-1:0] x_prod;
   logic [PYW-1:0] y_prod;

   assign x_prod = PXW'(x_ff) * PXW'(sw_c);
   assign y_prod = PYW'(y_ff) * PYW'(sh_c);

   // one restoring step per cycle on each loop
   logic [CW:0] x_try, x_diff;
   logic [HW:0] y_try, y_diff;
   logic        x_ge, y_ge;

   always_comb begin
      x_try  = {xrem_ff, xlow_ff[XW-1]};
      x_diff = x_try - {1'b0, tw_c};
      x_ge   = (x_try >= {1'b0, tw_c});
      y_try  = {yrem_ff, ylow_ff[YW-1]};
      y_diff = y_try - {1'b0, th_c};
      y_ge   = (y_try >= {1'b0, th_c});
   end

   // source raster address
   logic [SUM_W-1:0] addr_sum;

   assign addr_sum = SUM_W'(ylow_ff) * SUM_W'(sw_c) + SUM_W'(xlow_ff);

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (emit_go) begin
               state_in = ST_MUL;
            end
         end
         ST_MUL:  state_in = ST_DIV;
         ST_DIV: begin
            if (cnt_ff == CNT_W'(KMAX - 1)) begin
               state_in = ST_ADDR;
            end
         end
         ST_ADDR: state_in = ST_READ;
         ST_READ: state_in = ST_LOAD;
         ST_LOAD: begin
            if (rsp_free) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // control and configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         src_w_ff     <= '0;
         src_h_ff     <= '0;
         dst_w_ff     <= '0;
         dst_h_ff     <= '0;
         col_ff       <= '0;
         row_ff       <= '0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (csr_valid) begin
            unique case (csr_index)
               REG_SRC_WIDTH:  src_w_ff <= csr_data;
               REG_SRC_HEIGHT: src_h_ff <= csr_data;
               REG_DST_WIDTH:  dst_w_ff <= csr_data;
               REG_DST_HEIGHT: dst_h_ff <= csr_data;
               default: ;
            endcase
         end
         // counters step at accept; the item keeps its own copy
         if (emit_go) begin
            if (le_cur) begin
               col_ff <= '0;
               row_ff <= fe_cur ? '0 : (y_cur + YW'(1));
            end else begin
               col_ff <= x_cur + XW'(1);
               row_ff <= y_cur;
            end
         end
         if (state_ff == ST_MUL) begin
            cnt_ff <= '0;
         end else if (state_ff == ST_DIV) begin
            cnt_ff <= cnt_ff + CNT_W'(1);
         end
         if ((state_ff == ST_LOAD) && rsp_free) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      if (emit_go) begin
         x_ff  <= x_cur;
         y_ff  <= y_cur;
         le_ff <= le_cur;
         fe_ff <= fe_cur;
      end
      if (state_ff == ST_MUL) begin
         xrem_ff <= x_prod[PXW-1:XW];
         xlow_ff <= x_prod[XW-1:0];
         yrem_ff <= y_prod[PYW-1:YW];
         ylow_ff <= y_prod[YW-1:0];
      end else if (state_ff == ST_DIV) begin
         // shorter loop idles once its quotient is complete
         if (cnt_ff < CNT_W'(XW)) begin
            xrem_ff <= x_ge ? x_diff[CW-1:0] : x_try[CW-1:0];
            xlow_ff <= {xlow_ff[XW-2:0], x_ge};
         end
         if (cnt_ff < CNT_W'(YW)) begin
            yrem_ff <= y_ge ? y_diff[HW-1:0] : y_try[HW-1:0];
            ylow_ff <= {ylow_ff[YW-2:0], y_ge};
         end
      end
      if (state_ff == ST_ADDR) begin
         addr_ff <= addr_sum[ADDR_W-1:0];
      end
      if ((state_ff == ST_LOAD) && rsp_free) begin
         rsp_pix_ff <= rd_ff;
         rsp_col_ff <= POS_W'(x_ff);
         rsp_row_ff <= POS_W'(y_ff);
         rsp_le_ff  <= le_ff;
         rsp_fe_ff  <= fe_ff;
      end
   end

   // store port: writes only in IDLE, reads only in READ, so never together
   always_ff @(posedge clock) begin
      if (req_fire && (req_tuser == FUNC_LOAD)) begin
         store_mem[req_tdata[ADDR_W-1:0]] <= req_tdata[ADDR_W +: PIX_W];
      end
      if (state_ff == ST_READ) begin
         rd_ff <= store_mem[addr_ff];
      end
   end

   assign csr_ready  = 1'b1;
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {(RSP_DATA_W - PIX_IN_W - 2 * POS_W)'(0),
                        rsp_row_ff, rsp_col_ff, ALPHA_OPAQUE, rsp_pix_ff};
   assign rsp_tlast  = rsp_le_ff;
   assign rsp_tuser  = rsp_fe_ff;

   // checks
   a_xrem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> ({1'b0, xrem_ff} < {1'b0, tw_c}))
      else $error("column remainder not below target width");

   a_yrem_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DIV) |-> ({1'b0, yrem_ff} < {1'b0, th_c}))
      else $error("row remainder not below target height");

   a_sx_bound: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ADDR) |-> (CW'(xlow_ff) < sw_c))
      else $error("source column beyond source width");

   a_load_order: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_LOAD) |->
         ($past(state_ff) == ST_READ || $past(state_ff) == ST_LOAD))
      else $error("result load without a store read");

   a_frame_line: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_fe_ff) |-> rsp_le_ff)
      else $error("frame end without line end");

endmodule

[tb/sv/tb_nearest_neighbor_image_scaler_top.sv]
`timescale 1ns / 1ps
// Self-checking bench for nearest_neighbor_image_scaler_top: fills the frame store,
// walks the scaled raster and checks every result word against the predictor or the table.
// Depends on nnis_pkg and the scaler RTL; reads no files.
module tb_nearest_neighbor_image_scaler_top;
   import nnis_pkg::*;

   localparam int CLK_PERIOD    = 8;
   localparam int RESET_CYCLES  = 10;
   // an emit in flight must finish within this wait; keep a margin
   localparam int SETTLE_CYCLES = 24;
   // cycles with no word moving on any channel before the run is abandoned
   localparam int QUIET_LIMIT   = 1000;
   localparam int TOTAL_WORDS   = 1550;
   localparam int MAX_PRINTS    = 100;
   localparam int MAX_W         = MAX_WIDTH_DEF;
   localparam int MAX_H         = MAX_HEIGHT_DEF;

   // one scaled output pixel as the block presents it
   typedef struct {
      logic [31:0]      pixel;
      logic [POS_W-1:0] column;
      logic [POS_W-1:0] row;
      logic             line_end;
      logic             frame_end;
   } scaled_px_type;

   typedef enum logic { STEP_CSR, STEP_WORD } step_kind_type;

   // one row of the directed table: a register write or an input word
   typedef struct {
      step_kind_type        kind;
      logic [CSR_IDX_W-1:0] index;
      logic [CFG_W-1:0]     value;
      logic                 func;
      logic [ADDR_W-1:0]    address;
      logic [31:0]          load_px;
      bit                   known;      // result typed into the table
      bit                   known_hit;  // typed row gives a result
      scaled_px_type        known_px;
   } step_type;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tuser  = FUNC_LOAD;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tlast;
   logic                  rsp_tuser;
   logic                  csr_valid  = 1'b0;
   logic                  csr_ready;
   logic [CSR_IDX_W-1:0]  csr_index  = '0;
   logic [CFG_W-1:0]      csr_data   = '0;

   // predictor state: dimension registers, raster counters, frame store contents
   logic [CFG_W-1:0]  dim_reg [4] = '{default: '0};
   int unsigned       raster_col = 0;
   int unsigned       raster_row = 0;
   logic [PIX_W-1:0]  store_model [int unsigned];

   scaled_px_type     pixel_due [$];   // scaled pixels still owed by the block
   step_type          plan [$];        // directed table
   int                mismatch_count = 0;
   int                words_sent = 0;
   int                quiet_cycles = 0;
   bit                source_steady = 1'b0;  // sender idles not at all this phase
   bit                sink_steady = 1'b0;    // receiver stalls not at all this phase

   always #(CLK_PERIOD / 2) clock = ~clock;

   nearest_neighbor_image_scaler_top i_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // ---------------------------------------------------------------- predictor

   // register value as the block uses it: oversized values clamp to the maximum
   function automatic int unsigned eff_dim(input logic [CSR_IDX_W-1:0] idx);
      int unsigned limit;
      limit = (idx == REG_SRC_WIDTH || idx == REG_DST_WIDTH) ? MAX_W : MAX_H;
      return (dim_reg[idx] > limit) ? limit : dim_reg[idx];
   endfunction

   // where the next emit would read from; 0 if a zero dimension suppresses it
   function automatic bit source_address(output logic [ADDR_W-1:0] address,
                                         output int unsigned x, output int unsigned y);
      int unsigned sw, sh, tw, th;
      sw = eff_dim(REG_SRC_WIDTH);
      sh = eff_dim(REG_SRC_HEIGHT);
      tw = eff_dim(REG_DST_WIDTH);
      th = eff_dim(REG_DST_HEIGHT);
      address = '0;
      x = 0;
      y = 0;
      if (sw == 0 || sh == 0 || tw == 0 || th == 0)
         return 1'b0;
      // a counter left beyond a lowered target restarts at zero
      x = (raster_col >= tw) ? 0 : raster_col;
      y = (raster_row >= th) ? 0 : raster_row;
      address = ADDR_W'((y * sh / th) * sw + x * sw / tw);
      return 1'b1;
   endfunction

   // advance the predictor by one accepted word; 1 when it yields a pixel
   function automatic bit predict_word(input logic func, input logic [ADDR_W-1:0] addr,
                                       input logic [31:0] px, output scaled_px_type res);
      logic [ADDR_W-1:0] src;
      int unsigned       x, y, tw, th;
      res = '{default: '0};
      if (func == FUNC_LOAD) begin
         store_model[addr] = px[PIX_W-1:0];   // alpha dropped
         return 1'b0;
      end
      if (!source_address(src, x, y))
         return 1'b0;                         // counters held
      tw = eff_dim(REG_DST_WIDTH);
      th = eff_dim(REG_DST_HEIGHT);
      res.pixel     = {ALPHA_OPAQUE,
                       store_model.exists(src) ? store_model[src] : PIX_W'(0)};
      res.column    = POS_W'(x);
      res.row       = POS_W'(y);
      res.line_end  = (x == tw - 1);
      res.frame_end = res.line_end && (y == th - 1);
      if (res.line_end) begin
         raster_col = 0;
         raster_row = res.frame_end ? 0 : y + 1;
      end else begin
         raster_col = x + 1;
         raster_row = y;
      end
      return 1'b1;
   endfunction

   // ---------------------------------------------------------------- directed table

   function automatic void add_csr(input logic [CSR_IDX_W-1:0] idx,
                                   input logic [CFG_W-1:0] val);
      step_type s;
      s.kind  = STEP_CSR;
      s.index = idx;
      s.value = val;
      plan.push_back(s);
   endfunction

   function automatic void add_load(input logic [ADDR_W-1:0] addr, input logic [31:0] px);
      step_type s;
      s.kind    = STEP_WORD;
      s.func    = FUNC_LOAD;
      s.address = addr;
      s.load_px = px;
      plan.push_back(s);
   endfunction

   // emit whose result comes from the predictor
   function automatic void add_emit();
      step_type s;
      s.kind = STEP_WORD;
      s.func = FUNC_EMIT;
      plan.push_back(s);
   endfunction

   // emit whose result is obvious enough to type in
   function automatic void add_emit_known(input bit hit, input logic [31:0] px,
                                          input logic [POS_W-1:0] col,
                                          input logic [POS_W-1:0] row,
                                          input logic le, input logic fe);
      step_type s;
      s.kind      = STEP_WORD;
      s.func      = FUNC_EMIT;
      s.known     = 1'b1;
      s.known_hit = hit;
      s.known_px  = '{pixel: px, column: col, row: row, line_end: le, frame_end: fe};
      plan.push_back(s);
   endfunction

   // ---------------------------------------------------------------- drivers

   // one input word: optional idle gap, then hold until the handshake
   task automatic send_word(input logic func, input logic [ADDR_W-1:0] addr,
                            input logic [31:0] px, output bit hit,
                            output scaled_px_type res);
      int unsigned gap;
      bit          taken;
      gap = source_steady ? 0 : $urandom_range(0, 8);
      if (csr_valid)
         csr_valid <= 1'b0;
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= func;
      req_tdata  <= {{(REQ_DATA_W - ADDR_W - PIX_IN_W){1'b0}}, px, addr};
      // sample ready mid-cycle, where it is settled, then take the edge
      do begin
         @(negedge clock);
         taken = req_tready;
         @(posedge clock);
      end while (!taken);
      words_sent++;
      hit = predict_word(func, addr, px, res);
   endtask

   // emit word, preceded by a load if it would read a never-written entry
   task automatic emit_word(output bit hit, output scaled_px_type res);
      logic [ADDR_W-1:0] src;
      int unsigned       x, y;
      bit                found, unused_hit;
      scaled_px_type     unused_px;
      found = source_address(src, x, y);
      if (found && !store_model.exists(src))
         send_word(FUNC_LOAD, src, $urandom, unused_hit, unused_px);
      send_word(FUNC_EMIT, ADDR_W'($urandom), $urandom, hit, res);
   endtask

   // idle the block before touching its registers: all results in, plus a margin
   // for an emit that gives none
   task automatic drain_block();
      req_tvalid <= 1'b0;
      while (pixel_due.size() != 0)
         @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // back-to-back writes keep csr_valid high; the next input word lowers it
   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
      bit taken;
      if (!csr_valid)
         drain_block();
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do begin
         @(negedge clock);
         taken = csr_ready;
         @(posedge clock);
      end while (!taken);
      dim_reg[idx] = val;
   endtask

   // mostly small frames; now and then zero, the maximum or an oversized value
   function automatic logic [CFG_W-1:0] draw_dim();
      case ($urandom_range(0, 19))
         0:       return '0;
         1:       return '1;
         2:       return CFG_W'(MAX_W);
         3:       return CFG_W'($urandom_range(0, (1 << CFG_W) - 1));
         default: return CFG_W'($urandom_range(1, 8));
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic flag_mismatch(input string what, input logic [31:0] got,
                                input logic [31:0] want);
      if (mismatch_count < MAX_PRINTS)
         $display("%0t ns: %s: got %h, want %h", $time, what, got, want);
      mismatch_count++;
   endtask

   // a result word is taken at the next edge when valid and ready are up now;
   // sampling at the falling edge sees both settled
   always @(negedge clock) begin
      scaled_px_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pixel_due.size() == 0) begin
            flag_mismatch("result with nothing expected", rsp_tdata[31:0], 32'h0);
         end else begin
            want = pixel_due.pop_front();
            // tdata: [31:0] pixel, [41:32] column, [51:42] row
            if (rsp_tdata[31:0] !== want.pixel)
               flag_mismatch("out_pixel", rsp_tdata[31:0], want.pixel);
            if (rsp_tdata[41:32] !== want.column)
               flag_mismatch("out_column", 32'(rsp_tdata[41:32]), 32'(want.column));
            if (rsp_tdata[51:42] !== want.row)
               flag_mismatch("out_row", 32'(rsp_tdata[51:42]), 32'(want.row));
            if (rsp_tlast !== want.line_end)
               flag_mismatch("line_end", 32'(rsp_tlast), 32'(want.line_end));
            if (rsp_tuser !== want.frame_end)
               flag_mismatch("frame_end", 32'(rsp_tuser), 32'(want.frame_end));
         end
      end
   end

   // watchdog: nothing moving on any channel for too long ends the run
   always @(negedge clock) begin
      if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)
          || (csr_valid && csr_ready)) begin
         quiet_cycles = 0;
      end else begin
         quiet_cycles++;
         if (quiet_cycles >= QUIET_LIMIT) begin
            $display("end of test: mismatches");
            $finish;
         end
      end
   end

   // receiver: a random stall before each result word, none in steady phases
   initial begin
      int unsigned stall;
      bit          taken;
      forever begin
         stall = sink_steady ? 0 : $urandom_range(0, 8);
         if (stall != 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do begin
            @(negedge clock);
            taken = rsp_tvalid && !reset;
            @(posedge clock);
         end while (!taken);
      end
   end

   // ---------------------------------------------------------------- stimulus

   initial begin
      step_type          s;
      bit                hit;
      scaled_px_type     res;
      int unsigned       phase_len, region;
      logic [ADDR_W-1:0] addr;

      // all registers zero after reset: emit gives nothing
      add_emit_known(1'b0, '0, '0, '0, 1'b0, 1'b0);
      // 1x1 to 1x1: every emit is the single stored pixel, ending line and frame
      add_csr(REG_SRC_WIDTH, 11'd1);
      add_csr(REG_SRC_HEIGHT, 11'd1);
      add_csr(REG_DST_WIDTH, 11'd1);
      add_csr(REG_DST_HEIGHT, 11'd1);
      add_load(20'h0_0000, 32'hA512_3456);
      add_emit_known(1'b1, 32'hFF12_3456, 10'd0, 10'd0, 1'b1, 1'b1);
      add_emit_known(1'b1, 32'hFF12_3456, 10'd0, 10'd0, 1'b1, 1'b1);
      // all-ones at the top address, then all-zeros pixel
      add_load(20'hF_FFFF, 32'hFFFF_FFFF);
      add_load(20'h0_0000, 32'h0000_0000);
      add_emit_known(1'b1, 32'hFF00_0000, 10'd0, 10'd0, 1'b1, 1'b1);
      // oversized source width clamps to the maximum; 2x2 walk picks columns 0 and 512 of both rows
      add_csr(REG_SRC_WIDTH, 11'h7FF);
      add_csr(REG_SRC_HEIGHT, 11'd2);
      add_csr(REG_DST_WIDTH, 11'd2);
      add_csr(REG_DST_HEIGHT, 11'd2);
      add_load(20'd512, 32'h1122_3344);
      add_load(20'd1024, 32'h5566_7788);
      add_load(20'd1536, 32'h99AA_BBCC);
      repeat (5) add_emit();
      // zero height: no result and counters held
      add_csr(REG_DST_HEIGHT, 11'd0);
      add_emit_known(1'b0, '0, '0, '0, 1'b0, 1'b0);
      // narrower target with the column counter past it: column restarts
      add_csr(REG_DST_HEIGHT, 11'd2);
      add_csr(REG_DST_WIDTH, 11'd1);
      add_emit();
      // everything at the maximum
      add_csr(REG_SRC_WIDTH, CFG_W'(MAX_W));
      add_csr(REG_SRC_HEIGHT, CFG_W'(MAX_H));
      add_csr(REG_DST_WIDTH, CFG_W'(MAX_W));
      add_csr(REG_DST_HEIGHT, CFG_W'(MAX_H));
      repeat (2) add_emit();

      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (plan[i]) begin
         s = plan[i];
         if (s.kind == STEP_CSR) begin
            write_reg(s.index, s.value);
         end else if (s.func == FUNC_LOAD) begin
            send_word(FUNC_LOAD, s.address, s.load_px, hit, res);
         end else begin
            emit_word(hit, res);
            if (s.known) begin
               hit = s.known_hit;
               res = s.known_px;
            end
            if (hit)
               pixel_due.push_back(res);
         end
      end

      // random phases: new dimensions, then a mix of emits and loads
      while (words_sent < TOTAL_WORDS) begin
         source_steady = ($urandom_range(0, 3) == 0);
         sink_steady   = ($urandom_range(0, 3) == 0);
         write_reg(REG_SRC_WIDTH, draw_dim());
         write_reg(REG_SRC_HEIGHT, draw_dim());
         write_reg(REG_DST_WIDTH, draw_dim());
         write_reg(REG_DST_HEIGHT, draw_dim());
         phase_len = $urandom_range(20, 80);
         repeat (phase_len) begin
            if ($urandom_range(0, 99) < 65) begin
               emit_word(hit, res);
               if (hit)
                  pixel_due.push_back(res);
            end else begin
               // half the loads rewrite the live source frame, half land anywhere
               region = eff_dim(REG_SRC_WIDTH) * eff_dim(REG_SRC_HEIGHT);
               if (region != 0 && $urandom_range(0, 1) == 1)
                  addr = ADDR_W'($urandom_range(0, region - 1));
               else
                  addr = ADDR_W'($urandom);
               send_word(FUNC_LOAD, addr, $urandom, hit, res);
            end
         end
      end

      req_tvalid <= 1'b0;
      while (pixel_due.size() != 0)
         @(posedge clock);
      // catch any stray result after the last one owed
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (mismatch_count == 0 && pixel_due.size() == 0)
         $display("end of test: clean");
      else
         $display("end of test: mismatches");
      $finish;
   end

endmodule
